FILE: sv/plmst_pkg.sv
// ----------------------------------------------------------------------------
// plmst_pkg
// shared constants and codes of the per-label mean and stdev tracker
// ----------------------------------------------------------------------------
package plmst_pkg;

  localparam int NUM_LABELS_DEF = 256;
  localparam int COUNT_BITS_DEF = 24;

  localparam logic [31:0] VAR_FLOOR = 32'd6554;

  localparam logic OP_ADD   = 1'b0;
  localparam logic OP_CLEAR = 1'b1;

  localparam logic [1:0] ST_DONE   = 2'd0;
  localparam logic [1:0] ST_IGNORE = 2'd1;
  localparam logic [1:0] ST_FULL   = 2'd2;

  localparam int          CFG_AW     = 3;
  localparam logic        REG_BG_IDX = 1'b0;

endpackage

FILE: sv/plmst_ram.sv
// ----------------------------------------------------------------------------
// plmst_ram
// generic single write port ram with registered read
// ----------------------------------------------------------------------------
module plmst_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: sv/per_label_mean_stdev_tracker_unit.sv
// ----------------------------------------------------------------------------
// per_label_mean_stdev_tracker_unit
// per-label pixel count, sum and sum of squares with mean and stdev results
// ----------------------------------------------------------------------------
// channel  | ports                                    | direction
// in       | in_valid in_ready in_opcode/label/pixel  | beat in
// out      | out_valid out_ready out_status/...       | beat out
// cfg      | cfg_psel cfg_penable cfg_pwrite ...      | apb register port
//
// an add beat runs 16 mean divide steps, 32 steps for the
// mean of squares and 16 root steps, all in one shared subtractor
// clear and ignored beats skip the divide and root steps, full beats run the whole add path
// after reset a clearing pass over all NUM_LABELS entries runs before in_ready rises
// a waiting result stalls only the final cycle of the next beat
// ----------------------------------------------------------------------------
module per_label_mean_stdev_tracker_unit #(
  parameter int NUM_LABELS = plmst_pkg::NUM_LABELS_DEF,
  parameter int COUNT_BITS = plmst_pkg::COUNT_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic                        in_opcode,
  input  logic [7:0]                  in_label,
  input  logic [7:0]                  in_pixel,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [1:0]                  out_status,
  output logic [23:0]                 out_pixel_total,
  output logic [15:0]                 out_mean_value,
  output logic [15:0]                 out_stdev_value,
  input  logic                        cfg_psel,
  input  logic                        cfg_penable,
  input  logic                        cfg_pwrite,
  input  logic [plmst_pkg::CFG_AW-1:0] cfg_paddr,
  input  logic [31:0]                 cfg_pwdata,
  output logic [31:0]                 cfg_prdata,
  output logic                        cfg_pready
);

  localparam int AW   = $clog2(NUM_LABELS);
  localparam int LW   = (AW > 8) ? AW : 8;
  localparam int CB   = COUNT_BITS;
  localparam int SB   = CB + 8;
  localparam int QB   = CB + 16;
  localparam int MW   = CB + SB + QB;
  localparam int SUBW = (CB + 1 > 34) ? CB + 1 : 34;
  localparam int TW   = (CB > 24) ? CB : 24;

  typedef enum logic [3:0] {
    S_CLR, S_IDLE, S_LOOK, S_DIVM, S_DIVQ, S_MUL, S_VAR, S_SQRT, S_FIN
  } state_t;

  state_t          state_r, state_nxt;
  logic [AW-1:0]   clr_cnt_r, clr_cnt_nxt;
  logic [7:0]      bg_r, bg_nxt;
  logic            op_r, op_nxt;
  logic            ign_r, ign_nxt;
  logic [AW-1:0]   addr_r, addr_nxt;
  logic [7:0]      pix_r, pix_nxt;
  logic [CB-1:0]   n_r, n_nxt;
  logic [QB-1:0]   sq_r, sq_nxt;
  logic [SUBW-1:0] rem_r, rem_nxt;
  logic [31:0]     sh_r, sh_nxt;
  logic [4:0]      step_r, step_nxt;
  logic [15:0]     mean_r, mean_nxt;
  logic [31:0]     mm_r, mm_nxt;
  logic [15:0]     root_r, root_nxt;
  logic [1:0]      status_r, status_nxt;
  logic            out_valid_r, out_valid_nxt;
  logic [1:0]      out_status_r, out_status_nxt;
  logic [23:0]     out_total_r, out_total_nxt;
  logic [15:0]     out_mean_r, out_mean_nxt;
  logic [15:0]     out_sd_r, out_sd_nxt;

  logic [SUBW-1:0] sub_a, sub_b;
  logic [SUBW:0]   sub_d;
  logic            sub_ge;

  logic            ram_we;
  logic [AW-1:0]   ram_waddr, ram_raddr;
  logic [MW-1:0]   ram_wdata, ram_rdata;
  logic [LW-1:0]   lab_ext;
  logic [CB-1:0]   rd_n;
  logic [SB-1:0]   rd_sum, sum_new;
  logic [QB-1:0]   rd_sq, sq_new;
  logic            rd_full;
  logic [TW-1:0]   total_ext;
  logic            cfg_wr;

  assign lab_ext   = LW'(in_label);
  assign ram_raddr = lab_ext[AW-1:0];
  assign rd_n      = ram_rdata[MW-1 -: CB];
  assign rd_sum    = ram_rdata[SB+QB-1 -: SB];
  assign rd_sq     = ram_rdata[QB-1:0];
  assign rd_full   = &rd_n;
  assign sum_new   = rd_sum + SB'(pix_r);
  assign sq_new    = rd_sq + QB'(16'(pix_r) * 16'(pix_r));
  assign total_ext = TW'(n_r);

  plmst_ram #(.WIDTH(MW), .DEPTH(NUM_LABELS)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // shared subtractor
  always_comb begin
    case (state_r)
      S_DIVM, S_DIVQ: begin
        sub_a = {rem_r[SUBW-2:0], sh_r[31]};
        sub_b = SUBW'(n_r);
      end
      S_VAR: begin
        sub_a = SUBW'(sh_r);
        sub_b = SUBW'(mm_r);
      end
      S_SQRT: begin
        sub_a = SUBW'({rem_r[18:0], sh_r[31:30]});
        sub_b = SUBW'({root_r, 2'b01});
      end
      default: begin
        sub_a = '0;
        sub_b = '0;
      end
    endcase
    sub_d  = {1'b0, sub_a} - {1'b0, sub_b};
    sub_ge = ~sub_d[SUBW];
  end

  assign cfg_wr     = cfg_psel & cfg_penable & cfg_pwrite;
  assign cfg_pready = 1'b1;
  assign cfg_prdata = (cfg_paddr[2] == plmst_pkg::REG_BG_IDX) ? {24'd0, bg_r} : 32'd0;

  always_comb begin
    state_nxt      = state_r;
    clr_cnt_nxt    = clr_cnt_r;
    bg_nxt         = bg_r;
    op_nxt         = op_r;
    ign_nxt        = ign_r;
    addr_nxt       = addr_r;
    pix_nxt        = pix_r;
    n_nxt          = n_r;
    sq_nxt         = sq_r;
    rem_nxt        = rem_r;
    sh_nxt         = sh_r;
    step_nxt       = step_r;
    mean_nxt       = mean_r;
    mm_nxt         = mm_r;
    root_nxt       = root_r;
    status_nxt     = status_r;
    out_valid_nxt  = out_valid_r & ~out_ready;
    out_status_nxt = out_status_r;
    out_total_nxt  = out_total_r;
    out_mean_nxt   = out_mean_r;
    out_sd_nxt     = out_sd_r;
    ram_we         = 1'b0;
    ram_waddr      = addr_r;
    ram_wdata      = '0;

    if (cfg_wr && cfg_paddr[2] == plmst_pkg::REG_BG_IDX) begin
      bg_nxt = cfg_pwdata[7:0];
    end

    case (state_r)
      S_CLR: begin
        ram_we      = 1'b1;
        ram_waddr   = clr_cnt_r;
        clr_cnt_nxt = clr_cnt_r + 1'b1;
        if (32'(clr_cnt_r) == NUM_LABELS - 1) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          op_nxt    = in_opcode;
          ign_nxt   = (in_label == bg_r) || (32'(in_label) >= NUM_LABELS);
          addr_nxt  = lab_ext[AW-1:0];
          pix_nxt   = in_pixel;
          state_nxt = S_LOOK;
        end
      end
      S_LOOK: begin
        n_nxt      = '0;
        mean_nxt   = '0;
        root_nxt   = '0;
        status_nxt = plmst_pkg::ST_DONE;
        state_nxt  = S_FIN;
        if (ign_r) begin
          status_nxt = plmst_pkg::ST_IGNORE;
        end else if (op_r == plmst_pkg::OP_CLEAR) begin
          ram_we = 1'b1;
        end else begin
          step_nxt  = '0;
          state_nxt = S_DIVM;
          if (rd_full) begin
            status_nxt = plmst_pkg::ST_FULL;
            n_nxt      = rd_n;
            sq_nxt     = rd_sq;
            rem_nxt    = SUBW'(rd_sum >> 8);
            sh_nxt     = {rd_sum[7:0], 24'd0};
          end else begin
            ram_we     = 1'b1;
            ram_wdata  = {rd_n + 1'b1, sum_new, sq_new};
            n_nxt      = rd_n + 1'b1;
            sq_nxt     = sq_new;
            rem_nxt    = SUBW'(sum_new >> 8);
            sh_nxt     = {sum_new[7:0], 24'd0};
          end
        end
      end
      S_DIVM, S_DIVQ: begin
        rem_nxt  = sub_ge ? sub_d[SUBW-1:0] : sub_a;
        sh_nxt   = {sh_r[30:0], sub_ge};
        step_nxt = step_r + 1'b1;
        if (state_r == S_DIVM && step_r == 5'd15) begin
          mean_nxt  = {sh_r[14:0], sub_ge};
          rem_nxt   = SUBW'(sq_r >> 16);
          sh_nxt    = {sq_r[15:0], 16'd0};
          step_nxt  = '0;
          state_nxt = S_DIVQ;
        end else if (state_r == S_DIVQ && step_r == 5'd31) begin
          state_nxt = S_MUL;
        end
      end
      S_MUL: begin
        mm_nxt    = mean_r * mean_r;
        state_nxt = S_VAR;
      end
      S_VAR: begin
        sh_nxt    = (sub_ge && sub_d != '0) ? sub_d[31:0] : plmst_pkg::VAR_FLOOR;
        rem_nxt   = '0;
        root_nxt  = '0;
        step_nxt  = '0;
        state_nxt = S_SQRT;
      end
      S_SQRT: begin
        rem_nxt  = sub_ge ? sub_d[SUBW-1:0] : sub_a;
        root_nxt = {root_r[14:0], sub_ge};
        sh_nxt   = {sh_r[29:0], 2'b00};
        step_nxt = step_r + 1'b1;
        if (step_r == 5'd15) begin
          state_nxt = S_FIN;
        end
      end
      S_FIN: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = status_r;
          out_total_nxt  = total_ext[23:0];
          out_mean_nxt   = mean_r;
          out_sd_nxt     = root_r;
          state_nxt      = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLR;
      clr_cnt_r   <= '0;
      bg_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_cnt_r   <= clr_cnt_nxt;
      bg_r        <= bg_nxt;
      out_valid_r <= out_valid_nxt;
    end
    op_r         <= op_nxt;
    ign_r        <= ign_nxt;
    addr_r       <= addr_nxt;
    pix_r        <= pix_nxt;
    n_r          <= n_nxt;
    sq_r         <= sq_nxt;
    rem_r        <= rem_nxt;
    sh_r         <= sh_nxt;
    step_r       <= step_nxt;
    mean_r       <= mean_nxt;
    mm_r         <= mm_nxt;
    root_r       <= root_nxt;
    status_r     <= status_nxt;
    out_status_r <= out_status_nxt;
    out_total_r  <= out_total_nxt;
    out_mean_r   <= out_mean_nxt;
    out_sd_r     <= out_sd_nxt;
  end

  assign in_ready        = (state_r == S_IDLE);
  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_pixel_total = out_total_r;
  assign out_mean_value  = out_mean_r;
  assign out_stdev_value = out_sd_r;

endmodule
